[rtl/quadric_surface_sign_evaluator_defines.svh]
// assertion macros for the quadric surface sign evaluator
// depends on nothing; included by files that carry concurrent assertions
`ifndef QUADRIC_SURFACE_SIGN_EVALUATOR_DEFINES_SVH
`define QUADRIC_SURFACE_SIGN_EVALUATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define QSSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qsse assertion failed");
// delayed implication; argument n gives the delay
`define QSSE_ASSERT_DELAY(lbl, clk, rst_n, ante, cons, n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("qsse latency assertion failed");
`else
`define QSSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define QSSE_ASSERT_DELAY(lbl, clk, rst_n, ante, cons, n)
`endif
`endif

[rtl/qsse_pkg.sv]
// shared constants, codes and payload types of the quadric surface sign evaluator
// depends on nothing
package qsse_pkg;

    // word format
    localparam int W       = 32;
    localparam int F       = 16;
    localparam int H       = W / 2;
    localparam int OW      = W + 1;
    localparam int NW      = W + 2;
    localparam int AW      = W + 3;
    localparam int VW      = W + 4;
    localparam int KIND_W  = 4;
    localparam int IDX_W   = 3;

    // pipeline depth
    localparam int DIV_LAT = W + 2;
    localparam int LAST    = DIV_LAT + 6;
    localparam int NPOS    = LAST + 1;

    localparam logic signed [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_Q = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 4'd0,
        KIND_PX     = 4'd1,
        KIND_PY     = 4'd2,
        KIND_PZ     = 4'd3,
        KIND_PLANE  = 4'd4,
        KIND_SPHERE = 4'd5,
        KIND_CYL    = 4'd6,
        KIND_ECYL   = 4'd7,
        KIND_CONE   = 4'd8,
        KIND_ELL    = 4'd9
    } t_kind;

    typedef enum logic [IDX_W-1:0] {
        REG_KIND   = 3'd0,
        REG_COEF_A = 3'd1,
        REG_COEF_B = 3'd2,
        REG_COEF_C = 3'd3,
        REG_COEF_D = 3'd4,
        REG_SENSE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [W-1:0] point_x;
        logic signed [W-1:0] point_y;
        logic signed [W-1:0] point_z;
    } t_cmd;

    typedef struct packed {
        logic signed [W-1:0] side_value;
        logic                eval_error;
    } t_result;

    // per-transaction side data carried along the pipeline
    typedef struct packed {
        t_kind                kind;
        logic                 err;
        logic signed [AW-1:0] acc;
    } t_side;

endpackage

[rtl/quadric_surface_sign_evaluator.sv]
// top level of the quadric surface sign evaluator: config registers, operand set-up,
// three squares or products, three dividers, combine and sense scaling
// depends on qsse_pkg, qsse_mul, qsse_div and the defines header
//
// channel   signals                                   handshake
// command   i_start, o_busy, i_cmd                    taken when i_start && !o_busy
// result    o_result_valid, o_result                  one-cycle strobe, no back pressure
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,    written when valid && ready
//           i_cfg_data
//
// one point enters every cycle; o_busy is never raised
// a result strobes once its command has passed the operand register, the square
// multipliers, the one-bit-per-stage dividers that every transaction passes through,
// the combine register, the sense multiplier and the result register
// reset is synchronous active low and clears the valid pipe and the config registers
// the receiver cannot stall, so the pipeline never holds
`include "quadric_surface_sign_evaluator_defines.svh"
module quadric_surface_sign_evaluator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  qsse_pkg::t_cmd                    i_cmd,
    output logic                              o_result_valid,
    output qsse_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qsse_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [qsse_pkg::W-1:0]            i_cfg_data
);
    localparam int W    = qsse_pkg::W;
    localparam int OW   = qsse_pkg::OW;
    localparam int NW   = qsse_pkg::NW;
    localparam int AW   = qsse_pkg::AW;
    localparam int VW   = qsse_pkg::VW;
    localparam int LAST = qsse_pkg::LAST;
    localparam int PC   = 2 + qsse_pkg::DIV_LAT;

    qsse_pkg::t_kind     r_kind;
    logic signed [W-1:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d, r_sense;

    logic                 w_accept;
    logic signed [OW-1:0] n_op_a [0:2];
    logic signed [OW-1:0] n_op_b [0:2];
    logic signed [OW-1:0] r_op_a [0:2];
    logic signed [OW-1:0] r_op_b [0:2];
    qsse_pkg::t_side      n_sd0, n_sd3;
    qsse_pkg::t_side      r_sd [0:LAST-1];
    logic                 r_vld [0:LAST];

    logic signed [W-1:0]  w_t   [0:2];
    logic signed [NW-1:0] w_num [0:2];
    logic signed [W-1:0]  w_den [0:2];
    logic signed [W-1:0]  w_q   [0:2];
    logic signed [VW-1:0] n_sum;
    logic signed [W-1:0]  n_v, r_v, w_p;
    qsse_pkg::t_result    r_result;
    logic                 w_bad_kind, w_err_out;

    assign w_accept    = i_start && !o_busy;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= qsse_pkg::KIND_PX;
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= '0;
            r_sense  <= qsse_pkg::ONE_Q;
        end else if (i_cfg_valid) begin
            unique case (qsse_pkg::t_reg_idx'(i_cfg_index))
                qsse_pkg::REG_KIND: begin
                    r_kind <= qsse_pkg::t_kind'(i_cfg_data[qsse_pkg::KIND_W-1:0]);
                end
                qsse_pkg::REG_COEF_A: r_coef_a <= $signed(i_cfg_data);
                qsse_pkg::REG_COEF_B: r_coef_b <= $signed(i_cfg_data);
                qsse_pkg::REG_COEF_C: r_coef_c <= $signed(i_cfg_data);
                qsse_pkg::REG_COEF_D: r_coef_d <= $signed(i_cfg_data);
                qsse_pkg::REG_SENSE:  r_sense  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // operand set-up, plane offsets and error detection
    always_comb begin
        logic signed [OW-1:0] x, y, z, xa, ya, za, yb, zc;
        x  = OW'(i_cmd.point_x);
        y  = OW'(i_cmd.point_y);
        z  = OW'(i_cmd.point_z);
        xa = x - OW'(r_coef_a);
        ya = y - OW'(r_coef_a);
        za = z - OW'(r_coef_a);
        yb = y - OW'(r_coef_b);
        zc = z - OW'(r_coef_c);
        n_op_a[0] = x;
        n_op_b[0] = x;
        n_op_a[1] = y;
        n_op_b[1] = y;
        n_op_a[2] = z;
        n_op_b[2] = z;
        n_sd0.kind = r_kind;
        n_sd0.err  = 1'b0;
        n_sd0.acc  = '0;
        case (r_kind)
            qsse_pkg::KIND_PX: n_sd0.acc = AW'(xa);
            qsse_pkg::KIND_PY: n_sd0.acc = AW'(ya);
            qsse_pkg::KIND_PZ: n_sd0.acc = AW'(za);
            qsse_pkg::KIND_PLANE: begin
                n_op_a[0] = OW'(r_coef_a);
                n_op_a[1] = OW'(r_coef_b);
                n_op_a[2] = OW'(r_coef_c);
            end
            qsse_pkg::KIND_SPHERE: begin
                n_op_a[0] = xa;
                n_op_b[0] = xa;
                n_op_a[1] = yb;
                n_op_b[1] = yb;
                n_op_a[2] = zc;
                n_op_b[2] = zc;
                n_sd0.err = (r_coef_d == '0);
            end
            qsse_pkg::KIND_CYL: ;
            qsse_pkg::KIND_ECYL: n_sd0.err = (r_coef_a == '0) || (r_coef_b == '0);
            qsse_pkg::KIND_CONE: begin
                n_op_a[2] = za;
                n_op_b[2] = za;
                n_sd0.err = (r_coef_b == '0);
            end
            qsse_pkg::KIND_ELL: begin
                n_sd0.err = (r_coef_a == '0) || (r_coef_b == '0) || (r_coef_c == '0);
            end
            default: n_sd0.err = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_op_a[i] <= n_op_a[i];
            r_op_b[i] <= n_op_b[i];
        end
    end

    // three squares or products
    for (genvar g = 0; g < 3; g++) begin : g_mul
        qsse_mul u_mul (
            .i_clk (i_clk),
            .i_a   (r_op_a[g]),
            .i_b   (r_op_b[g]),
            .o_p   (w_t[g])
        );
    end

    // sums without division and divider operands
    always_comb begin
        logic signed [AW-1:0] sum2, sum3;
        sum2  = AW'(w_t[0]) + AW'(w_t[1]);
        sum3  = sum2 + AW'(w_t[2]);
        n_sd3 = r_sd[2];
        case (r_sd[2].kind) inside
            qsse_pkg::KIND_PX, qsse_pkg::KIND_PY, qsse_pkg::KIND_PZ: ;
            qsse_pkg::KIND_PLANE: n_sd3.acc = sum3 - AW'(r_coef_d);
            qsse_pkg::KIND_CYL:   n_sd3.acc = sum2 - AW'(r_coef_a);
            qsse_pkg::KIND_CONE:  n_sd3.acc = sum2;
            default:              n_sd3.acc = '0;
        endcase
        w_num[0] = (r_sd[2].kind == qsse_pkg::KIND_SPHERE) ? NW'(sum3) : NW'(w_t[0]);
        w_den[0] = (r_sd[2].kind == qsse_pkg::KIND_SPHERE) ? r_coef_d : r_coef_a;
        w_num[1] = NW'(w_t[1]);
        w_den[1] = r_coef_b;
        w_num[2] = NW'(w_t[2]);
        w_den[2] = (r_sd[2].kind == qsse_pkg::KIND_CONE) ? r_coef_b : r_coef_c;
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        qsse_div u_div (
            .i_clk (i_clk),
            .i_num (w_num[g]),
            .i_den (w_den[g]),
            .o_quo (w_q[g])
        );
    end

    // combine quotients with the carried partial value, saturate
    always_comb begin
        n_sum = VW'(r_sd[PC].acc);
        case (r_sd[PC].kind)
            qsse_pkg::KIND_SPHERE: n_sum = n_sum + VW'(w_q[0]) - VW'(qsse_pkg::ONE_Q);
            qsse_pkg::KIND_ECYL: begin
                n_sum = n_sum + VW'(w_q[0]) + VW'(w_q[1]) - VW'(qsse_pkg::ONE_Q);
            end
            qsse_pkg::KIND_CONE: n_sum = n_sum - VW'(w_q[2]);
            qsse_pkg::KIND_ELL: begin
                n_sum = n_sum + VW'(w_q[0]) + VW'(w_q[1]) + VW'(w_q[2])
                      - VW'(qsse_pkg::ONE_Q);
            end
            default: ;
        endcase
        if (n_sum > VW'(qsse_pkg::WMAX)) begin
            n_v = qsse_pkg::WMAX;
        end else if (n_sum < VW'(qsse_pkg::WMIN)) begin
            n_v = qsse_pkg::WMIN;
        end else begin
            n_v = $signed(n_sum[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    // sense scaling
    qsse_mul u_sense (
        .i_clk (i_clk),
        .i_a   (OW'(r_v)),
        .i_b   (OW'(r_sense)),
        .o_p   (w_p)
    );

    // side data pipe and result register
    always_ff @(posedge i_clk) begin
        r_sd[0] <= n_sd0;
        for (int i = 0; i < LAST - 1; i++) begin
            if (i == 2) begin
                r_sd[i+1] <= n_sd3;
            end else begin
                r_sd[i+1] <= r_sd[i];
            end
        end
        r_result.side_value <= r_sd[LAST-1].err ? '0 : w_p;
        r_result.eval_error <= r_sd[LAST-1].err;
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= w_accept;
            for (int i = 0; i < LAST; i++) begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    assign o_result_valid = r_vld[LAST];
    assign o_result       = r_result;

    // terms for the checks below
    assign w_bad_kind = (r_kind == qsse_pkg::KIND_NONE) || (r_kind > qsse_pkg::KIND_ELL);
    assign w_err_out  = o_result_valid && o_result.eval_error;

    // every accepted transaction returns a result strobe
    `QSSE_ASSERT_DELAY(a_latency, i_clk, i_rst_n, w_accept, o_result_valid, qsse_pkg::NPOS)
    // an invalid kind always ends as an error result
    `QSSE_ASSERT_DELAY(a_bad_kind, i_clk, i_rst_n, w_accept && w_bad_kind, o_result.eval_error, qsse_pkg::NPOS)
    // an error result carries a zero value
    `QSSE_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, w_err_out, o_result.side_value == '0)
endmodule

[rtl/qsse_mul.sv]
// two-stage fixed point multiplier: floor(a*b / 2^F) saturated to the word range
// depends on qsse_pkg
module qsse_mul (
    input  logic                            i_clk,
    input  logic signed [qsse_pkg::OW-1:0]  i_a,
    input  logic signed [qsse_pkg::OW-1:0]  i_b,
    output logic signed [qsse_pkg::W-1:0]   o_p
);
    localparam int LW = qsse_pkg::H + 1;
    localparam int UW = qsse_pkg::OW - qsse_pkg::H;
    localparam int PW = 2 * qsse_pkg::OW;
    localparam logic signed [PW-1:0] PMAX = PW'(qsse_pkg::WMAX);
    localparam logic signed [PW-1:0] PMIN = PW'(qsse_pkg::WMIN);

    logic signed [qsse_pkg::OW+LW-1:0] n_lo, r_lo;
    logic signed [qsse_pkg::OW+UW-1:0] n_hi, r_hi;
    logic signed [PW-1:0]              n_full, n_shr;
    logic signed [qsse_pkg::W-1:0]     n_p, r_p;

    // partial products on the low and high halves of b
    always_comb begin
        n_lo = i_a * $signed({1'b0, i_b[qsse_pkg::H-1:0]});
        n_hi = i_a * $signed(i_b[qsse_pkg::OW-1:qsse_pkg::H]);
    end

    // sum, floor shift and saturation
    always_comb begin
        n_full = (PW'(r_hi) <<< qsse_pkg::H) + PW'(r_lo);
        n_shr  = n_full >>> qsse_pkg::F;
        if (n_shr > PMAX) begin
            n_p = qsse_pkg::WMAX;
        end else if (n_shr < PMIN) begin
            n_p = qsse_pkg::WMIN;
        end else begin
            n_p = $signed(n_shr[qsse_pkg::W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_p  <= n_p;
    end

    assign o_p = r_p;
endmodule

[rtl/qsse_div.sv]
// pipelined restoring divider: n * 2^F / d truncated toward zero, saturated
// depends on qsse_pkg; one quotient bit per stage
module qsse_div (
    input  logic                            i_clk,
    input  logic signed [qsse_pkg::NW-1:0]  i_num,
    input  logic signed [qsse_pkg::W-1:0]   i_den,
    output logic signed [qsse_pkg::W-1:0]   o_quo
);
    localparam int W  = qsse_pkg::W;
    localparam int DW = qsse_pkg::NW + qsse_pkg::F;
    localparam int RW = W + 1;

    logic [qsse_pkg::NW-1:0] n_nm;
    logic [W-1:0]            n_dm;
    logic [DW-1:0]           n_dv;
    logic                    n_ovf;

    logic [RW-1:0] r_rem [0:W];
    logic [W-1:0]  r_low [0:W];
    logic [W-1:0]  r_q   [0:W];
    logic [W-1:0]  r_dm  [0:W];
    logic          r_neg [0:W];
    logic          r_ovf [0:W];

    logic [RW-1:0] n_rem [0:W-1];
    logic [W-1:0]  n_q   [0:W-1];

    logic [W-1:0]          n_lim, n_mag;
    logic signed [W-1:0]   n_quo, r_quo;

    // magnitudes, overflow test on the top dividend bits
    always_comb begin
        n_nm  = i_num[qsse_pkg::NW-1] ? (~i_num + 1'b1) : i_num;
        n_dm  = i_den[W-1] ? (~i_den + 1'b1) : i_den;
        n_dv  = {n_nm, {qsse_pkg::F{1'b0}}};
        n_ovf = (DW'(n_dv[DW-1:W]) >= DW'(n_dm));
    end

    // one compare and subtract per stage
    always_comb begin
        logic [RW:0] t;
        logic        ge;
        for (int i = 0; i < W; i++) begin
            t        = {r_rem[i], r_low[i][W-1]};
            ge       = (t >= (RW+1)'(r_dm[i]));
            n_rem[i] = ge ? RW'(t - (RW+1)'(r_dm[i])) : RW'(t);
            n_q[i]   = {r_q[i][W-2:0], ge};
        end
    end

    // clamp and sign
    always_comb begin
        n_lim = r_neg[W] ? qsse_pkg::WMIN : qsse_pkg::WMAX;
        n_mag = (r_ovf[W] || (r_q[W] > n_lim)) ? n_lim : r_q[W];
        n_quo = r_neg[W] ? $signed(~n_mag + 1'b1) : $signed(n_mag);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(n_dv[DW-1:W]);
        r_low[0] <= n_dv[W-1:0];
        r_q[0]   <= '0;
        r_dm[0]  <= n_dm;
        r_neg[0] <= i_num[qsse_pkg::NW-1] ^ i_den[W-1];
        r_ovf[0] <= n_ovf;
        for (int i = 0; i < W; i++) begin
            r_rem[i+1] <= n_rem[i];
            r_low[i+1] <= {r_low[i][W-2:0], 1'b0};
            r_q[i+1]   <= n_q[i];
            r_dm[i+1]  <= r_dm[i];
            r_neg[i+1] <= r_neg[i];
            r_ovf[i+1] <= r_ovf[i];
        end
        r_quo <= n_quo;
    end

    assign o_quo = r_quo;
endmodule

[sim/qsse_checker.sv]
// checker for the quadric surface sign evaluator: watches the command, config and
// result channels, predicts each result and compares; depends on qsse_pkg
`timescale 1ns / 100ps
module qsse_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  qsse_pkg::t_cmd               i_cmd,
    input  logic                         i_result_valid,
    input  qsse_pkg::t_result            i_result,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [qsse_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [qsse_pkg::W-1:0]       i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    localparam int W = qsse_pkg::W;
    localparam int F = qsse_pkg::F;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    logic [3:0]          shadow_kind;
    longint              shadow_a, shadow_b, shadow_c, shadow_d, shadow_sense;
    qsse_pkg::t_result   expected_q[$];
    int                  mismatches;

    function automatic longint clamp_word(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // fixed point product, floor shift, saturate; operands fit in 36 bits
    function automatic longint fx_mul(input longint a, input longint b);
        logic signed [127:0] p;
        p = $signed(128'(a)) * $signed(128'(b));
        p = p >>> F;
        if (p > QMAX) return QMAX;
        if (p < QMIN) return QMIN;
        return longint'(p);
    endfunction

    // n * 2^F / d toward zero, saturated; zero divisor flags an error
    function automatic longint fx_div(input longint n, input longint d, inout logic err);
        logic [127:0] un, ud, q;
        logic neg;
        longint lim;
        if (d == 0) begin
            err = 1'b1;
            return 0;
        end
        neg = (n < 0) != (d < 0);
        un = n < 0 ? 128'(-n) : 128'(n);
        ud = d < 0 ? 128'(-d) : 128'(d);
        q = (un << F) / ud;
        lim = neg ? 64'sd2147483648 : QMAX;
        if (q > 128'(lim)) q = 128'(lim);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic qsse_pkg::t_result side_of_point(input qsse_pkg::t_cmd p);
        longint x, y, z, v, dx, dy, dz;
        logic err;
        qsse_pkg::t_result r;
        x = longint'(p.point_x);
        y = longint'(p.point_y);
        z = longint'(p.point_z);
        err = 1'b0;
        v = 0;
        case (shadow_kind)
            qsse_pkg::KIND_PX: v = x - shadow_a;
            qsse_pkg::KIND_PY: v = y - shadow_a;
            qsse_pkg::KIND_PZ: v = z - shadow_a;
            qsse_pkg::KIND_PLANE: v = fx_mul(shadow_a, x) + fx_mul(shadow_b, y)
                                      + fx_mul(shadow_c, z) - shadow_d;
            qsse_pkg::KIND_SPHERE: begin
                dx = x - shadow_a;
                dy = y - shadow_b;
                dz = z - shadow_c;
                v = fx_div(fx_mul(dx, dx) + fx_mul(dy, dy) + fx_mul(dz, dz),
                           shadow_d, err) - 65536;
            end
            qsse_pkg::KIND_CYL: v = fx_mul(x, x) + fx_mul(y, y) - shadow_a;
            qsse_pkg::KIND_ECYL: v = fx_div(fx_mul(x, x), shadow_a, err)
                                     + fx_div(fx_mul(y, y), shadow_b, err) - 65536;
            qsse_pkg::KIND_CONE: begin
                dz = z - shadow_a;
                v = fx_mul(x, x) + fx_mul(y, y) - fx_div(fx_mul(dz, dz), shadow_b, err);
            end
            qsse_pkg::KIND_ELL: v = fx_div(fx_mul(x, x), shadow_a, err)
                                    + fx_div(fx_mul(y, y), shadow_b, err)
                                    + fx_div(fx_mul(z, z), shadow_c, err) - 65536;
            default: err = 1'b1;
        endcase
        r.eval_error = err;
        r.side_value = err ? '0 : W'(fx_mul(clamp_word(v), shadow_sense));
        return r;
    endfunction

    // shadow registers, predictions and result comparison
    always @(posedge i_clk) begin
        qsse_pkg::t_result want;
        if (!i_rst_n) begin
            shadow_kind  <= qsse_pkg::KIND_PX;
            shadow_a     = 0;
            shadow_b     = 0;
            shadow_c     = 0;
            shadow_d     = 0;
            shadow_sense = 65536;
            expected_q.delete();
            o_fail_count <= 0;
            o_checked    <= 0;
            o_pending    <= 0;
            mismatches   = 0;
        end else begin
            if (i_result_valid) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", i_result);
                end else begin
                    want = expected_q.pop_front();
                    if (want.side_value !== i_result.side_value
                        || want.eval_error !== i_result.eval_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: side_value exp %h got %h, error exp %b got %b",
                                     want.side_value, i_result.side_value,
                                     want.eval_error, i_result.eval_error);
                    end
                end
                o_checked <= o_checked + 1;
            end
            if (i_start && !i_busy)
                expected_q.push_back(side_of_point(i_cmd));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    qsse_pkg::REG_KIND:   shadow_kind <= i_cfg_data[3:0];
                    qsse_pkg::REG_COEF_A: shadow_a = longint'($signed(i_cfg_data));
                    qsse_pkg::REG_COEF_B: shadow_b = longint'($signed(i_cfg_data));
                    qsse_pkg::REG_COEF_C: shadow_c = longint'($signed(i_cfg_data));
                    qsse_pkg::REG_COEF_D: shadow_d = longint'($signed(i_cfg_data));
                    qsse_pkg::REG_SENSE:  shadow_sense = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            o_pending    <= expected_q.size();
            o_fail_count <= mismatches;
        end
    end
endmodule

[sim/tb_top.sv]
// stimulus top for the quadric surface sign evaluator: clock, reset, config phases
// and point traffic; depends on qsse_pkg, qsse_checker and the block
`timescale 1ns / 100ps
module tb_top;
    localparam int W       = qsse_pkg::W;
    localparam int IDX_W   = qsse_pkg::IDX_W;
    localparam int LATENCY = W + 9;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    qsse_pkg::t_cmd     i_cmd;
    logic               o_result_valid;
    qsse_pkg::t_result  o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [W-1:0]       i_cfg_data;
    int                 fail_count, pending, checked;
    int                 idle_pct;
    int                 points_sent;

    quadric_surface_sign_evaluator DUT (.*);

    qsse_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_cmd,
        .i_result_valid(o_result_valid), .i_result(o_result),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(20 * 400000);
        $display("Regression FAIL");
        $finish;
    end

    // one config transaction; valid is then lowered before the task returns
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one point transaction, with optional idle cycles ahead of it
    task automatic send_point(input logic [W-1:0] x, input logic [W-1:0] y,
                              input logic [W-1:0] z);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= '{point_x: x, point_y: y, point_z: z};
        do @(posedge i_clk); while (o_busy);
        points_sent++;
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return W'($signed($urandom_range(20 * 65536)) - 10 * 65536);
            2: return W'($signed($urandom_range(512)) - 256);
            default: return {$urandom_range(1) ? qsse_pkg::WMAX : qsse_pkg::WMIN};
        endcase
    endfunction

    function automatic logic [W-1:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 0;
            2: return {$urandom_range(1) ? qsse_pkg::WMAX : qsse_pkg::WMIN};
            default: return W'($signed($urandom_range(16 * 65536)) - 8 * 65536);
        endcase
    endfunction

    initial begin
        logic [W-1:0] edge_vals[6];
        int mode;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_pct = 0;
        points_sent = 0;
        edge_vals = '{qsse_pkg::WMAX, qsse_pkg::WMIN, 0, qsse_pkg::ONE_Q, -qsse_pkg::ONE_Q,
                      32'h0000_0001};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, then every kind with extreme and simple points
        for (int i = 0; i < 3; i++) send_point(edge_vals[i], edge_vals[i + 1], edge_vals[i + 2]);
        drain();
        for (int k = 0; k < 12; k++) begin
            write_reg(qsse_pkg::REG_KIND, k == 10 ? 4'd15 : (k == 11 ? 32'hFFFF_FFF9 : W'(k)));
            write_reg(qsse_pkg::REG_COEF_A, k % 2 ? qsse_pkg::ONE_Q : 2 * qsse_pkg::ONE_Q);
            write_reg(qsse_pkg::REG_COEF_B, k == 7 ? 0 : qsse_pkg::ONE_Q);
            write_reg(qsse_pkg::REG_COEF_C, qsse_pkg::ONE_Q);
            write_reg(qsse_pkg::REG_COEF_D, k == 5 ? 0 : 4 * qsse_pkg::ONE_Q);
            write_reg(qsse_pkg::REG_SENSE, k % 3 == 0 ? qsse_pkg::WMIN :
                      (k % 3 == 1 ? qsse_pkg::WMAX : -qsse_pkg::ONE_Q));
            write_reg(3'd7, $urandom());
            send_point(qsse_pkg::WMAX, qsse_pkg::WMIN, qsse_pkg::ONE_Q);
            send_point(edge_vals[k % 6], edge_vals[(k + 2) % 6], edge_vals[(k + 4) % 6]);
            drain();
        end

        // random phases: new settings each, cycling idle patterns
        for (int ph = 0; ph < 40; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 55;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            write_reg(qsse_pkg::REG_KIND,
                      $urandom_range(9) == 0 ? $urandom() : $urandom_range(1, 9));
            write_reg(qsse_pkg::REG_COEF_A, rand_coef());
            write_reg(qsse_pkg::REG_COEF_B, rand_coef());
            write_reg(qsse_pkg::REG_COEF_C, rand_coef());
            write_reg(qsse_pkg::REG_COEF_D, rand_coef());
            write_reg(qsse_pkg::REG_SENSE,
                      $urandom_range(3) == 0 ? rand_coef() : qsse_pkg::ONE_Q);
            mode = $urandom_range(3);
            for (int n = 0; n < 30; n++)
                send_point(rand_coord($urandom_range(4) == 0 ? 0 : mode),
                           rand_coord(mode), rand_coord(mode));
            drain();
        end

        $display("sent %0d points over 52 register settings, %0d results checked",
                 points_sent, checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
